FILE: hw/rtl/pta_pkg.sv
`default_nettype none

package pta_pkg;

	// wide signed word for the apex arithmetic, dividend width, multiplier operand width
	localparam int W  = 136;
	localparam int DW = W + 2;
	localparam int MB = 35;
	localparam int CW = $clog2(DW + 1);

	// item modes
	localparam logic [1:0] MODE_RECORD = 2'd0;
	localparam logic [1:0] MODE_REPORT = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_FIRST = 2'd1;
	localparam logic [1:0] KIND_APEX  = 2'd2;

	// interpolated component index
	localparam logic [1:0] COMP_X   = 2'd0;
	localparam logic [1:0] COMP_Y   = 2'd1;
	localparam logic [1:0] COMP_SPD = 2'd2;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] t;
		logic [31:0] s;
	} sample_t;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pta_arith.sv
`default_nettype none

module pta_arith import pta_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  arith_req_t        req,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] res,
	output logic [W-1:0]      res_mag,
	output logic              done
);

	typedef enum logic [4:0] {
		U_IDLE  = 5'b00001,
		U_MUL   = 5'b00010,
		U_DPREP = 5'b00100,
		U_DIV   = 5'b01000,
		U_SIGN  = 5'b10000
	} ustate_t;

	ustate_t         st_q;
	arith_op_t       op_q;
	logic [DW:0]     acc_q;
	logic [DW-1:0]   x_q;
	logic [DW-1:0]   y_q;
	logic [CW-1:0]   cnt_q;
	logic            neg_q;
	logic signed [W-1:0] res_q;
	logic [W-1:0]    mag_q;
	logic            done_q;

	logic [W-1:0]    a_mag;
	logic [W-1:0]    bw_mag;
	logic [MB-1:0]   b_nar;
	logic [MB-1:0]   b_mag;
	logic [DW:0]     rem_try;
	logic            ge;
	logic [W-1:0]    src;

	// operand magnitudes
	assign a_mag  = a[W-1] ? W'(-a) : W'(a);
	assign bw_mag = b[W-1] ? W'(-b) : W'(b);
	assign b_nar  = b[MB-1:0];
	assign b_mag  = b_nar[MB-1] ? MB'(-b_nar) : b_nar;

	// restoring divide step
	assign rem_try = {acc_q[DW-1:0], x_q[DW-1]};
	assign ge      = rem_try >= {1'b0, y_q};
	assign src     = (op_q == OP_MUL) ? acc_q[W-1:0] : x_q[W-1:0];

	// sequencer for shift-add multiply and rounded divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				U_IDLE: begin
					if (req.start) begin
						op_q <= req.op;
						x_q  <= {{(DW-W){1'b0}}, a_mag};
						if (req.op == OP_MUL) begin
							y_q   <= {{(DW-MB){1'b0}}, b_mag};
							neg_q <= a[W-1] ^ b_nar[MB-1];
							acc_q <= '0;
							cnt_q <= CW'(MB);
							st_q  <= U_MUL;
						end else begin
							y_q   <= {{(DW-W){1'b0}}, bw_mag};
							neg_q <= a[W-1] ^ b[W-1];
							st_q  <= U_DPREP;
						end
					end
				end
				U_MUL: begin
					if (y_q[0]) begin
						acc_q <= acc_q + {1'b0, x_q};
					end
					x_q   <= {x_q[DW-2:0], 1'b0};
					y_q   <= {1'b0, y_q[DW-1:1]};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						st_q <= U_SIGN;
					end
				end
				U_DPREP: begin
					// (2|n| + |d|) / (2|d|) rounds half away from zero
					x_q   <= {x_q[DW-2:0], 1'b0} + y_q;
					y_q   <= {y_q[DW-2:0], 1'b0};
					acc_q <= '0;
					cnt_q <= CW'(DW);
					st_q  <= U_DIV;
				end
				U_DIV: begin
					acc_q <= ge ? (rem_try - {1'b0, y_q}) : rem_try;
					x_q   <= {x_q[DW-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						st_q <= U_SIGN;
					end
				end
				U_SIGN: begin
					mag_q  <= src;
					res_q  <= neg_q ? W'(-src) : W'(src);
					done_q <= 1'b1;
					st_q   <= U_IDLE;
				end
				default: st_q <= U_IDLE;
			endcase
		end
	end

	assign res     = res_q;
	assign res_mag = mag_q;
	assign done    = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/peak_tracker_quadratic_apex.sv
// channel | handshake         | payload
// input   | in_valid/in_stall | mode, sample_x, sample_y, sample_time, sample_speed
// output  | out_valid/out_stall | apex_kind, apex_x, apex_y, apex_time, apex_speed
//
// record, clear and unused-mode items are handled in the idle state and leave in_stall low.
// a report with an interpolated apex runs its products and quotients through one shared
// shift-add multiplier (23 products) and restoring divider (up to four quotients, one fewer
// when the curvature is too flat for the vertex divide). other reports go straight to the
// output register. in_stall is high while a report is worked on.
// reset clears all sample state; a held output stalls only the end of a report.
`default_nettype none

module peak_tracker_quadratic_apex import pta_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire  [1:0]        mode,
	input  wire  signed [31:0] sample_x,
	input  wire  signed [31:0] sample_y,
	input  wire  [31:0]       sample_time,
	input  wire  [31:0]       sample_speed,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [1:0]        apex_kind,
	output logic signed [31:0] apex_x,
	output logic signed [31:0] apex_y,
	output logic [31:0]       apex_time,
	output logic [31:0]       apex_speed
);

	typedef enum logic [19:0] {
		S_IDLE   = 20'h00001,
		S_P      = 20'h00002,
		S_Q      = 20'h00004,
		S_PH     = 20'h00008,
		S_QH     = 20'h00010,
		S_LHS    = 20'h00020,
		S_W      = 20'h00040,
		S_VDIV   = 20'h00080,
		S_VCLAMP = 20'h00100,
		S_DN1    = 20'h00200,
		S_DN2    = 20'h00400,
		S_A1     = 20'h00800,
		S_A2     = 20'h01000,
		S_B1     = 20'h02000,
		S_B2     = 20'h04000,
		S_N      = 20'h08000,
		S_QDIV   = 20'h10000,
		S_R1     = 20'h20000,
		S_R2     = 20'h40000,
		S_OUT    = 20'h80000
	} state_t;

	localparam logic signed [W-1:0] LIM_HI = {{(W-42){1'b0}}, 42'h100_0000_0000};
	localparam logic signed [W-1:0] LIM_LO = -LIM_HI;
	localparam logic signed [33:0]  FLAT_SCALE = 34'sd1000000000;

	function automatic logic signed [W-1:0] wx(input logic signed [33:0] v);
		return {{(W-34){v[33]}}, v};
	endfunction

	state_t   state_q;
	logic     issued_q;
	sample_t  first_q, peak_q, before_q, after_q, prev_q;
	logic [1:0] cnt_q;
	logic     latest_q, firstpk_q;
	logic [1:0] comp_q;

	logic signed [W-1:0] p_q, q_q, den_q, num_q, dn_q, tmp_q;
	logic signed [33:0]  off_q;
	logic signed [41:0]  r_q;

	logic [1:0]  rk_q;
	logic [31:0] rx_q, ry_q, rt_q, rs_q;
	logic        out_valid_q;

	logic        accept;
	sample_t     smp;
	logic signed [33:0] h1, h2, hd, d1, d2, lo, hi, h1c, v0, v1, v2, dv1, dv2;
	logic signed [42:0] sum;
	logic [31:0] sat;
	arith_req_t  req;
	logic signed [W-1:0] op_a, op_b, ar_res;
	logic [W-1:0] ar_mag;
	logic        ar_done;
	logic        compute;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign smp      = '{x: sample_x, y: sample_y, t: sample_time, s: sample_speed};

	// neighbour offsets and height steps
	assign h1 = $signed({2'b00, peak_q.t}) - $signed({2'b00, before_q.t});
	assign h2 = $signed({2'b00, after_q.t}) - $signed({2'b00, before_q.t});
	assign hd = $signed({2'b00, after_q.t}) - $signed({2'b00, peak_q.t});
	assign d1 = $signed({{2{peak_q.y[31]}}, peak_q.y}) - $signed({{2{before_q.y[31]}}, before_q.y});
	assign d2 = $signed({{2{after_q.y[31]}}, after_q.y}) - $signed({{2{before_q.y[31]}}, before_q.y});
	assign lo  = (h2 < 0) ? h2 : 34'sd0;
	assign hi  = (h2 < 0) ? 34'sd0 : h2;
	assign h1c = (h1 < lo) ? lo : ((h1 > hi) ? hi : h1);

	// component values for interpolation
	always_comb begin
		case (comp_q)
			COMP_X: begin
				v0 = {{2{before_q.x[31]}}, before_q.x};
				v1 = {{2{peak_q.x[31]}}, peak_q.x};
				v2 = {{2{after_q.x[31]}}, after_q.x};
			end
			COMP_Y: begin
				v0 = {{2{before_q.y[31]}}, before_q.y};
				v1 = {{2{peak_q.y[31]}}, peak_q.y};
				v2 = {{2{after_q.y[31]}}, after_q.y};
			end
			default: begin
				v0 = {2'b00, before_q.s};
				v1 = {2'b00, peak_q.s};
				v2 = {2'b00, after_q.s};
			end
		endcase
	end
	assign dv1 = v1 - v0;
	assign dv2 = v2 - v0;

	// add back the base value and saturate to the field range
	assign sum = {r_q[41], r_q} + {{9{v0[33]}}, v0};
	always_comb begin
		if (comp_q == COMP_SPD) begin
			if (sum < 0) begin
				sat = 32'h0000_0000;
			end else if (sum > 43'sd4294967295) begin
				sat = 32'hffff_ffff;
			end else begin
				sat = sum[31:0];
			end
		end else begin
			if (sum > 43'sd2147483647) begin
				sat = 32'h7fff_ffff;
			end else if (sum < -43'sd2147483648) begin
				sat = 32'h8000_0000;
			end else begin
				sat = sum[31:0];
			end
		end
	end

	// operand selection for the shared unit
	always_comb begin
		op_a    = '0;
		op_b    = '0;
		compute = 1'b1;
		unique case (state_q)
			S_P:    begin op_a = wx(d2);   op_b = wx(h1); end
			S_Q:    begin op_a = wx(d1);   op_b = wx(h2); end
			S_PH:   begin op_a = p_q;      op_b = wx(h1); end
			S_QH:   begin op_a = q_q;      op_b = wx(h2); end
			S_LHS:  begin op_a = den_q;    op_b = wx(FLAT_SCALE); end
			S_W:    begin op_a = wx(h1);   op_b = wx(hd); end
			S_VDIV: begin op_a = num_q;    op_b = den_q; end
			S_DN1:  begin op_a = wx(h1);   op_b = wx(h2); end
			S_DN2:  begin op_a = tmp_q;    op_b = wx(hd); end
			S_A1:   begin op_a = wx(dv1);  op_b = wx(h2); end
			S_A2:   begin op_a = tmp_q;    op_b = wx(h2 - off_q); end
			S_B1:   begin op_a = wx(dv2);  op_b = wx(h1); end
			S_B2:   begin op_a = tmp_q;    op_b = wx(h1 - off_q); end
			S_N:    begin op_a = q_q;      op_b = wx(off_q); end
			S_QDIV: begin op_a = tmp_q;    op_b = dn_q; end
			default: compute = 1'b0;
		endcase
	end

	assign req.start = compute && !issued_q;
	assign req.op    = (state_q == S_VDIV || state_q == S_QDIV) ? OP_DIV : OP_MUL;

	pta_arith u_arith (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.a       (op_a),
		.b       (op_b),
		.res     (ar_res),
		.res_mag (ar_mag),
		.done    (ar_done)
	);

	// sample tracking, report sequencing and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			cnt_q       <= 2'd0;
			latest_q    <= 1'b0;
			firstpk_q   <= 1'b0;
			first_q     <= '0;
			peak_q      <= '0;
			before_q    <= '0;
			after_q     <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ar_done) begin
				issued_q <= 1'b0;
			end else if (req.start) begin
				issued_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_RECORD: begin
								if (cnt_q == 2'd0) begin
									first_q   <= smp;
									peak_q    <= smp;
									latest_q  <= 1'b1;
									firstpk_q <= 1'b1;
								end else if ($signed(sample_y) > $signed(peak_q.y)) begin
									before_q  <= prev_q;
									peak_q    <= smp;
									latest_q  <= 1'b1;
									firstpk_q <= 1'b0;
								end else if (latest_q) begin
									after_q  <= smp;
									latest_q <= 1'b0;
								end
								prev_q <= smp;
								if (cnt_q != 2'd2) begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							MODE_CLEAR: begin
								cnt_q     <= 2'd0;
								latest_q  <= 1'b0;
								firstpk_q <= 1'b0;
								first_q   <= '0;
								peak_q    <= '0;
								before_q  <= '0;
								after_q   <= '0;
								prev_q    <= '0;
							end
							MODE_REPORT: begin
								if (cnt_q != 2'd2 || latest_q) begin
									rk_q <= KIND_NONE;
									rx_q <= '0; ry_q <= '0; rt_q <= '0; rs_q <= '0;
									state_q <= S_OUT;
								end else if (firstpk_q) begin
									rk_q <= KIND_FIRST;
									rx_q <= first_q.x; ry_q <= first_q.y;
									rt_q <= first_q.t; rs_q <= first_q.s;
									state_q <= S_OUT;
								end else begin
									rk_q <= KIND_APEX;
									rx_q <= peak_q.x; ry_q <= peak_q.y;
									rt_q <= peak_q.t; rs_q <= peak_q.s;
									if (h1 == 0 || h2 == 0 || hd == 0) begin
										state_q <= S_OUT;
									end else begin
										state_q <= S_P;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_P: if (ar_done) begin p_q <= ar_res; state_q <= S_Q; end
				S_Q: if (ar_done) begin
					q_q     <= ar_res;
					den_q   <= (p_q - ar_res) <<< 1;
					state_q <= S_PH;
				end
				S_PH: if (ar_done) begin tmp_q <= ar_res; state_q <= S_QH; end
				S_QH: if (ar_done) begin num_q <= tmp_q - ar_res; state_q <= S_LHS; end
				S_LHS: if (ar_done) begin tmp_q <= $signed(ar_mag); state_q <= S_W; end
				S_W: if (ar_done) begin
					// curvature too small: fall back to the peak time
					if ($unsigned(tmp_q) > ar_mag) begin
						state_q <= S_VDIV;
					end else begin
						off_q   <= h1c;
						state_q <= S_DN1;
					end
				end
				S_VDIV: if (ar_done) begin tmp_q <= ar_res; state_q <= S_VCLAMP; end
				S_VCLAMP: begin
					if (tmp_q < wx(lo)) begin
						off_q <= lo;
					end else if (tmp_q > wx(hi)) begin
						off_q <= hi;
					end else begin
						off_q <= tmp_q[33:0];
					end
					state_q <= S_DN1;
				end
				S_DN1: if (ar_done) begin tmp_q <= ar_res; state_q <= S_DN2; end
				S_DN2: if (ar_done) begin
					dn_q    <= ar_res;
					comp_q  <= COMP_X;
					state_q <= S_A1;
				end
				S_A1: if (ar_done) begin tmp_q <= ar_res; state_q <= S_A2; end
				S_A2: if (ar_done) begin p_q <= ar_res; state_q <= S_B1; end
				S_B1: if (ar_done) begin tmp_q <= ar_res; state_q <= S_B2; end
				S_B2: if (ar_done) begin q_q <= p_q - ar_res; state_q <= S_N; end
				S_N: if (ar_done) begin tmp_q <= ar_res; state_q <= S_QDIV; end
				S_QDIV: if (ar_done) begin tmp_q <= ar_res; state_q <= S_R1; end
				S_R1: begin
					if (tmp_q > LIM_HI) begin
						r_q <= LIM_HI[41:0];
					end else if (tmp_q < LIM_LO) begin
						r_q <= LIM_LO[41:0];
					end else begin
						r_q <= tmp_q[41:0];
					end
					state_q <= S_R2;
				end
				S_R2: begin
					case (comp_q)
						COMP_X: rx_q <= sat;
						COMP_Y: ry_q <= sat;
						default: rs_q <= sat;
					endcase
					if (comp_q == COMP_SPD) begin
						rt_q    <= before_q.t + off_q[31:0];
						state_q <= S_OUT;
					end else begin
						comp_q  <= comp_q + 1'b1;
						state_q <= S_A1;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						apex_kind   <= rk_q;
						apex_x      <= rx_q;
						apex_y      <= ry_q;
						apex_time   <= rt_q;
						apex_speed  <= rs_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		ar_done |-> issued_q)
		else $error("arith result without a request");

	a_report_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_REPORT) |=> (state_q != S_IDLE))
		else $error("report item dropped");

	a_off_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DN1) |-> (off_q >= lo && off_q <= hi))
		else $error("apex offset outside neighbour interval");
`endif

endmodule

`default_nettype wire

FILE: sim/apex_checker.sv
`default_nettype none

module apex_checker import pta_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire                in_stall,
	input  wire  [1:0]         mode,
	input  wire  signed [31:0] sample_x,
	input  wire  signed [31:0] sample_y,
	input  wire  [31:0]        sample_time,
	input  wire  [31:0]        sample_speed,
	input  wire                out_valid,
	input  wire                out_stall,
	input  wire  [1:0]         apex_kind,
	input  wire  signed [31:0] apex_x,
	input  wire  signed [31:0] apex_y,
	input  wire  [31:0]        apex_time,
	input  wire  [31:0]        apex_speed,
	output int                 mismatches,
	output int                 waiting
);

	typedef logic signed [199:0] wide_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] t;
		logic [31:0] s;
	} apex_t;

	// tracked trajectory state
	int unsigned seen;
	sample_t     first_s, peak_s, before_s, after_s, prev_s;
	bit          peak_latest, peak_first;
	apex_t       apex_q[$];

	function automatic wide_t sext(logic [31:0] v);
		return {{168{v[31]}}, v};
	endfunction

	function automatic wide_t zext(logic [31:0] v);
		return {168'd0, v};
	endfunction

	function automatic wide_t wabs(wide_t v);
		return v < 0 ? -v : v;
	endfunction

	function automatic wide_t wclamp(wide_t v, wide_t lo, wide_t hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// quotient rounded to nearest, ties away from zero
	function automatic wide_t div_round(wide_t n, wide_t d);
		wide_t q;
		q = (2 * wabs(n) + wabs(d)) / (2 * wabs(d));
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	// quadratic through the three points, evaluated at offset s from the first
	function automatic wide_t eval_quad(wide_t v0, wide_t v1, wide_t v2, wide_t h1, wide_t h2,
			wide_t s, wide_t lo, wide_t hi);
		wide_t a, b, n, dn, r;
		a  = (v1 - v0) * h2 * (h2 - s);
		b  = (v2 - v0) * h1 * (h1 - s);
		n  = s * (a - b);
		dn = h1 * h2 * (h2 - h1);
		r  = wclamp(div_round(n, dn), -(wide_t'(1) <<< 40), wide_t'(1) <<< 40) + v0;
		return wclamp(r, lo, hi);
	endfunction

	function automatic apex_t predict_apex();
		apex_t r;
		wide_t t0, h1, h2, lo, hi, d1, d2, den, num, w, off;
		r = '{KIND_NONE, 0, 0, 0, 0};
		if (seen < 2 || peak_latest)
			return r;
		if (peak_first) begin
			r = '{KIND_FIRST, first_s.x, first_s.y, first_s.t, first_s.s};
			return r;
		end
		r.kind = KIND_APEX;
		t0 = zext(before_s.t);
		h1 = zext(peak_s.t) - t0;
		h2 = zext(after_s.t) - t0;
		// coinciding times give the peak itself
		if (h1 == 0 || h2 == 0 || h1 == h2) begin
			r = '{KIND_APEX, peak_s.x, peak_s.y, peak_s.t, peak_s.s};
			return r;
		end
		lo  = h2 < 0 ? h2 : 0;
		hi  = h2 < 0 ? 0 : h2;
		d1  = sext(peak_s.y) - sext(before_s.y);
		d2  = sext(after_s.y) - sext(before_s.y);
		den = 2 * (d2 * h1 - d1 * h2);
		num = d2 * h1 * h1 - d1 * h2 * h2;
		w   = h1 * (h2 - h1);
		// nearly flat curvature falls back to the peak time
		if (wabs(den * 1000000000) > wabs(w))
			off = wclamp(div_round(num, den), lo, hi);
		else
			off = wclamp(h1, lo, hi);
		r.x = 32'(eval_quad(sext(before_s.x), sext(peak_s.x), sext(after_s.x), h1, h2, off,
			-(wide_t'(1) <<< 31), (wide_t'(1) <<< 31) - 1));
		r.y = 32'(eval_quad(sext(before_s.y), sext(peak_s.y), sext(after_s.y), h1, h2, off,
			-(wide_t'(1) <<< 31), (wide_t'(1) <<< 31) - 1));
		r.t = 32'(t0 + off);
		r.s = 32'(eval_quad(zext(before_s.s), zext(peak_s.s), zext(after_s.s), h1, h2, off,
			0, (wide_t'(1) <<< 32) - 1));
		return r;
	endfunction

	// update on accepted items, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		sample_t cur;
		apex_t   exp_a;
		if (!arst_n) begin
			seen        = 0;
			first_s     = '0;
			peak_s      = '0;
			before_s    = '0;
			after_s     = '0;
			prev_s      = '0;
			peak_latest = 0;
			peak_first  = 0;
			mismatches  = 0;
			apex_q.delete();
		end else begin
			if (in_valid && !in_stall) begin
				cur = '{sample_x, sample_y, sample_time, sample_speed};
				case (mode)
					MODE_RECORD: begin
						if (seen == 0) begin
							first_s     = cur;
							peak_s      = cur;
							peak_latest = 1;
							peak_first  = 1;
						end else if ($signed(cur.y) > $signed(peak_s.y)) begin
							before_s    = prev_s;
							peak_s      = cur;
							peak_latest = 1;
							peak_first  = 0;
						end else if (peak_latest) begin
							after_s     = cur;
							peak_latest = 0;
						end
						prev_s = cur;
						if (seen != 32'hFFFF_FFFF)
							seen++;
					end
					MODE_REPORT: apex_q.insert(apex_q.size(), predict_apex());
					MODE_CLEAR: begin
						seen        = 0;
						first_s     = '0;
						peak_s      = '0;
						before_s    = '0;
						after_s     = '0;
						prev_s      = '0;
						peak_latest = 0;
						peak_first  = 0;
					end
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (apex_q.size() == 0) begin
					$error("apex result with none expected");
					mismatches++;
				end else begin
					exp_a = apex_q.pop_front();
					if (apex_kind !== exp_a.kind) begin
						$error("apex_kind expected %0d got %0d", exp_a.kind, apex_kind);
						mismatches++;
					end
					if (apex_x !== exp_a.x) begin
						$error("apex_x expected %0d got %0d", $signed(exp_a.x), apex_x);
						mismatches++;
					end
					if (apex_y !== exp_a.y) begin
						$error("apex_y expected %0d got %0d", $signed(exp_a.y), apex_y);
						mismatches++;
					end
					if (apex_time !== exp_a.t) begin
						$error("apex_time expected %0d got %0d", exp_a.t, apex_time);
						mismatches++;
					end
					if (apex_speed !== exp_a.s) begin
						$error("apex_speed expected %0d got %0d", exp_a.s, apex_speed);
						mismatches++;
					end
				end
			end
		end
		waiting = apex_q.size();
	end

endmodule

`default_nettype wire

FILE: sim/tb_peak_tracker_quadratic_apex.sv
`default_nettype none

module tb_peak_tracker_quadratic_apex;
	import pta_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int ITEM_GOAL  = 500;
	localparam int STALL_MAX  = 20000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic [1:0]         mode = MODE_RECORD;
	logic signed [31:0] sample_x = 0;
	logic signed [31:0] sample_y = 0;
	logic [31:0]        sample_time = 0;
	logic [31:0]        sample_speed = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic [1:0]         apex_kind;
	logic signed [31:0] apex_x, apex_y;
	logic [31:0]        apex_time, apex_speed;
	int                 mismatches, waiting;
	int                 sent = 0;
	int                 quiet = 0;
	int                 phase = 0;

	peak_tracker_quadratic_apex uut (
		.clk, .arst_n, .in_valid, .in_stall, .mode, .sample_x, .sample_y, .sample_time,
		.sample_speed, .out_valid, .out_stall, .apex_kind, .apex_x, .apex_y, .apex_time,
		.apex_speed
	);

	apex_checker chk (
		.clk, .arst_n, .in_valid, .in_stall, .mode, .sample_x, .sample_y, .sample_time,
		.sample_speed, .out_valid, .out_stall, .apex_kind, .apex_x, .apex_y, .apex_time,
		.apex_speed, .mismatches, .waiting
	);

	always #6 clk = ~clk;

	// receiver stalls, rate set by phase
	always @(posedge clk)
		out_stall <= $urandom_range(0, 99) < (phase == 0 ? 59 : (phase == 1 ? 31 : 0));

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_MAX) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// one item: random gaps first, then hold until accepted
	task automatic send(logic [1:0] m, logic [31:0] x, logic [31:0] y, logic [31:0] t,
			logic [31:0] s);
		while ($urandom_range(0, 99) < (phase == 0 ? 31 : (phase == 1 ? 59 : 0))) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid     <= 1;
		mode         <= m;
		sample_x     <= x;
		sample_y     <= y;
		sample_time  <= t;
		sample_speed <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		phase = sent < ITEM_GOAL / 3 ? 0 : (sent < 2 * ITEM_GOAL / 3 ? 1 : 2);
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return $urandom_range(0, 1 << 20);
			default: return $urandom;
		endcase
	endfunction

	// clear, a rise and fall of samples around a peak with occasional reports, then a report
	task automatic trajectory();
		int n, pk;
		logic [31:0] t, y;
		n  = $urandom_range(1, 8);
		pk = $urandom_range(0, n - 1);
		t  = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 16);
		y  = $urandom_range(0, 3) == 0 ? pick32() : $urandom_range(0, 1 << 18) - (1 << 17);
		send(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 11))
				0: t = $urandom;
				1: ;
				default: t = t + $urandom_range(1, 1 << 20);
			endcase
			if ($urandom_range(0, 9) == 0)
				y = pick32();
			else if (i <= pk)
				y = y + $urandom_range(0, 1 << 20);
			else
				y = y - $urandom_range(0, 1 << 20);
			send(MODE_RECORD, $urandom_range(0, 1) ? pick32() : $urandom_range(0, 1 << 18),
				y, t, pick32());
			if ($urandom_range(0, 5) == 0)
				send(MODE_REPORT, $urandom, $urandom, $urandom, $urandom);
		end
		send(MODE_REPORT, $urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty, single sample, extremes, first peak, latest peak
		send(MODE_REPORT, 0, 0, 0, 0);
		send(MODE_RECORD, 32'h8000_0000, 32'h8000_0000, 0, 0);
		send(MODE_REPORT, 0, 0, 0, 0);
		send(MODE_RECORD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(MODE_REPORT, 0, 0, 0, 0);
		send(MODE_RECORD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		send(MODE_REPORT, 0, 0, 0, 0);
		send(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// peak is first sample
		send(MODE_RECORD, 5, 100, 10, 7);
		send(MODE_RECORD, 6, 50, 20, 8);
		send(MODE_REPORT, 0, 0, 0, 0);
		// flat case with reversed times, then equal times
		send(MODE_CLEAR, 0, 0, 0, 0);
		send(MODE_RECORD, 1, 0, 0, 3);
		send(MODE_RECORD, 2, 2, 2, 4);
		send(MODE_RECORD, 3, 1, 1, 5);
		send(MODE_REPORT, 0, 0, 0, 0);
		send(MODE_RECORD, 9, 9, 2, 9);
		send(MODE_RECORD, 8, 8, 2, 8);
		send(MODE_REPORT, 0, 0, 0, 0);
		// equal peaks and overflowing interpolation
		send(MODE_CLEAR, 0, 0, 0, 0);
		send(MODE_RECORD, 32'h8000_0000, 32'h8000_0000, 0, 0);
		send(MODE_RECORD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF);
		send(MODE_RECORD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
		send(MODE_REPORT, 0, 0, 0, 0);

		// random: mostly trajectories, some noise
		while (sent < ITEM_GOAL) begin
			if ($urandom_range(0, 4) == 0)
				send(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
			else
				trajectory();
		end
		in_valid <= 0;

		// let the checker take in the last accepted item before draining
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
